>>> hdl/jet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jet_pkg
// Shared types, microcode and helpers of the Julia escape-time unit.
// ----------------------------------------------------------------------------
package jet_pkg;

    // data widths fixed by the field formats
    localparam int IN_W   = 32;   // coordinate and constant width
    localparam int ZW     = 33;   // signed width of z after the first pass
    localparam int MW     = 32;   // multiplier operand magnitude width
    localparam int PW     = 2 * MW;
    localparam int CNT_OW = 7;    // escape_count field width
    localparam int COL_W  = 8;    // pixel_color field width
    localparam int CFG_IW = 1;    // register index width

    // register indexes
    localparam logic [CFG_IW-1:0] REG_C_REAL = 1'b0;
    localparam logic [CFG_IW-1:0] REG_C_IMAG = 1'b1;

    // register reset values
    localparam logic [IN_W-1:0] C_REAL_RST = 32'hFC7AE148;  // -59055800
    localparam logic [IN_W-1:0] C_IMAG_RST = 32'h01083126;  //  17314086

    // color cap on the count
    localparam logic [7:0] COLOR_CAP = 8'd63;

    // microcode program counter
    localparam int UPC_W = 3;

    // step addresses
    localparam logic [UPC_W-1:0] UA_IDLE = 3'd0;
    localparam logic [UPC_W-1:0] UA_MRR  = 3'd1;
    localparam logic [UPC_W-1:0] UA_MII  = 3'd2;
    localparam logic [UPC_W-1:0] UA_MRI  = 3'd3;
    localparam logic [UPC_W-1:0] UA_ITER = 3'd4;
    localparam logic [UPC_W-1:0] UA_DONE = 3'd5;

    // multiplier operand selection
    localparam logic [1:0] MOP_NONE = 2'd0;
    localparam logic [1:0] MOP_RR   = 2'd1;
    localparam logic [1:0] MOP_II   = 2'd2;
    localparam logic [1:0] MOP_RI   = 2'd3;

    // product writeback
    localparam logic [1:0] WB_NONE = 2'd0;
    localparam logic [1:0] WB_SQRE = 2'd1;
    localparam logic [1:0] WB_SQIM = 2'd2;
    localparam logic [1:0] WB_ITER = 2'd3;

    // sequencer branch kind
    localparam logic [1:0] BR_NEXT     = 2'd0;
    localparam logic [1:0] BR_WAIT_IN  = 2'd1;
    localparam logic [1:0] BR_ITER     = 2'd2;
    localparam logic [1:0] BR_WAIT_OUT = 2'd3;

    typedef struct packed {
        logic [1:0]       mul_op;
        logic [1:0]       wb;
        logic [1:0]       br;
        logic [UPC_W-1:0] target;
    } t_ctrl;

    // control store
    function automatic t_ctrl ucode(input logic [UPC_W-1:0] addr);
        t_ctrl w;
        w = '0;
        unique case (addr)
            UA_IDLE: w = '{mul_op: MOP_NONE, wb: WB_NONE, br: BR_WAIT_IN,  target: UA_MRR};
            UA_MRR:  w = '{mul_op: MOP_RR,   wb: WB_NONE, br: BR_NEXT,     target: UA_IDLE};
            UA_MII:  w = '{mul_op: MOP_II,   wb: WB_SQRE, br: BR_NEXT,     target: UA_IDLE};
            UA_MRI:  w = '{mul_op: MOP_RI,   wb: WB_SQIM, br: BR_NEXT,     target: UA_IDLE};
            UA_ITER: w = '{mul_op: MOP_NONE, wb: WB_ITER, br: BR_ITER,     target: UA_MRR};
            UA_DONE: w = '{mul_op: MOP_NONE, wb: WB_NONE, br: BR_WAIT_OUT, target: UA_IDLE};
            default: w = '{mul_op: MOP_NONE, wb: WB_NONE, br: BR_NEXT,     target: UA_IDLE};
        endcase
        return w;
    endfunction

    // color byte from the full iteration count
    function automatic logic [COL_W-1:0] color_of(input logic [7:0] n);
        logic [5:0] m;
        m = (n > COLOR_CAP) ? COLOR_CAP[5:0] : n[5:0];
        return {m[5:3], 5'b0} + {3'b0, m[5:1]};
    endfunction

endpackage

>>> hdl/julia_escape_time_fixed.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julia_escape_time_fixed
// Escape-time count and color of one Julia-set point in signed fixed point.
// ----------------------------------------------------------------------------
// One input beat carries a start point z0; the unit iterates z = z^2 + c with
// c from two registers and returns one beat with the escape count and color.
// Each pass of the loop uses the single shared 32x32 multiplier, which forms
// re*re, im*im and re*im one after another, followed by a combined
// writeback, escape test and update step. A point makes count+1 passes if
// it escapes and MAX_ITER passes otherwise. The result sits in an output
// register, so the next point is taken while it waits to be read.
// The user writes c_real and c_imag only while the unit is idle; the unit
// itself does not enforce this.
module julia_escape_time_fixed #(
    parameter int FRAC_BITS = 26,
    parameter int MAX_ITER  = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write port
    input  logic                         i_cfg_we,
    input  logic [jet_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  logic [jet_pkg::IN_W-1:0]     i_cfg_data,
    // input stream
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [63:0]                  i_s_tdata,   // point_real[31:0], point_imag[63:32]
    // output stream
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [15:0]                  o_m_tdata    // escape_count[6:0], pixel_color[14:7]
);
    import jet_pkg::*;

    localparam int SQW = PW + 1 - FRAC_BITS;          // shifted product width
    localparam int CW  = $clog2(MAX_ITER + 1);        // iteration count width
    localparam logic [SQW:0]   FOUR     = (SQW+1)'(64'd4 << FRAC_BITS);
    localparam logic [CW-1:0]  CNT_LAST = CW'(MAX_ITER - 1);

    // configuration registers
    logic [IN_W-1:0] r_c_real, r_c_imag;

    // sequencer
    logic [UPC_W-1:0] r_pc, n_pc;
    t_ctrl            ctl;

    // datapath
    logic signed [ZW-1:0] r_re, r_im;
    logic [SQW-1:0]       r_sqre, r_sqim;
    logic [PW-1:0]        r_prod;
    logic                 r_prod_neg;
    logic [CW-1:0]        r_cnt;

    // output register
    logic        r_out_valid;
    logic [15:0] r_out_data;

    logic s_acc, out_free;
    logic [MW-1:0] mag_re, mag_im, mul_a, mul_b;
    logic          mul_neg;
    logic [SQW-1:0] prod_sq, prod_x;
    logic [SQW:0]   sum_sq;
    logic           escape, last;
    logic signed [ZW-1:0] cross_z, re_next, im_next, c_re_x, c_im_x;

    assign ctl      = ucode(r_pc);
    assign s_acc    = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;

    assign o_s_tready = (r_pc == UA_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // operand magnitudes
    assign mag_re = MW'(r_re[ZW-1] ? -r_re : r_re);
    assign mag_im = MW'(r_im[ZW-1] ? -r_im : r_im);

    // multiplier operand select
    always_comb begin
        mul_a   = mag_re;
        mul_b   = mag_re;
        mul_neg = 1'b0;
        unique case (ctl.mul_op)
            MOP_RR: begin
                mul_a = mag_re;
                mul_b = mag_re;
            end
            MOP_II: begin
                mul_a = mag_im;
                mul_b = mag_im;
            end
            MOP_RI: begin
                mul_a   = mag_re;
                mul_b   = mag_im;
                mul_neg = r_re[ZW-1] ^ r_im[ZW-1];
            end
            MOP_NONE: begin
                mul_a = mag_re;
                mul_b = mag_re;
            end
            default: ;
        endcase
    end

    // shifted products, truncated toward zero on the magnitude
    assign prod_sq = SQW'(r_prod >> FRAC_BITS);
    assign prod_x  = SQW'(r_prod >> (FRAC_BITS - 1));

    // escape test and next z
    assign sum_sq  = {1'b0, r_sqre} + {1'b0, r_sqim};
    assign escape  = sum_sq > FOUR;
    assign last    = (r_cnt == CNT_LAST);
    assign c_re_x  = {r_c_real[IN_W-1], r_c_real};
    assign c_im_x  = {r_c_imag[IN_W-1], r_c_imag};
    assign cross_z = r_prod_neg ? -$signed(ZW'(prod_x)) : $signed(ZW'(prod_x));
    assign re_next = $signed(ZW'(r_sqre)) - $signed(ZW'(r_sqim)) + c_re_x;
    assign im_next = cross_z + c_im_x;

    // next step address
    always_comb begin
        n_pc = r_pc;
        unique case (ctl.br)
            BR_NEXT:     n_pc = r_pc + 1'b1;
            BR_WAIT_IN:  n_pc = s_acc ? ctl.target : r_pc;
            BR_ITER:     n_pc = (escape || last) ? r_pc + 1'b1 : ctl.target;
            BR_WAIT_OUT: n_pc = out_free ? ctl.target : r_pc;
            default:     n_pc = UA_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= UA_IDLE;
            r_out_valid <= 1'b0;
            r_c_real    <= C_REAL_RST;
            r_c_imag    <= C_IMAG_RST;
        end else begin
            r_pc <= n_pc;
            if (ctl.br == BR_WAIT_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we && i_cfg_idx == REG_C_REAL) begin
                r_c_real <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == REG_C_IMAG) begin
                r_c_imag <= i_cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        // load a new point
        if (ctl.br == BR_WAIT_IN && s_acc) begin
            r_re  <= ZW'($signed(i_s_tdata[31:0]));
            r_im  <= ZW'($signed(i_s_tdata[63:32]));
            r_cnt <= '0;
        end
        // shared multiplier
        if (ctl.mul_op != MOP_NONE) begin
            r_prod     <= PW'(mul_a) * PW'(mul_b);
            r_prod_neg <= mul_neg;
        end
        // product writeback
        if (ctl.wb == WB_SQRE) begin
            r_sqre <= prod_sq;
        end
        if (ctl.wb == WB_SQIM) begin
            r_sqim <= prod_sq;
        end
        if (ctl.wb == WB_ITER && !escape) begin
            r_re  <= re_next;
            r_im  <= im_next;
            r_cnt <= r_cnt + 1'b1;
        end
        // result beat
        if (ctl.br == BR_WAIT_OUT && out_free) begin
            r_out_data <= {1'b0, color_of(8'(r_cnt)), CNT_OW'(r_cnt)};
        end
    end

endmodule

>>> hdl/jet_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jet_checker
// Port-level checks of the Julia escape-time unit, bound to its top level.
// ----------------------------------------------------------------------------
module jet_checker #(
    parameter int MAX_ITER = 64
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cfg_we,
    input logic [jet_pkg::CFG_IW-1:0]  i_cfg_idx,
    input logic [jet_pkg::IN_W-1:0]    i_cfg_data,
    input logic                        i_s_tvalid,
    input logic                        o_s_tready,
    input logic [63:0]                 i_s_tdata,   // point_real[31:0], point_imag[63:32]
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [15:0]                 o_m_tdata    // escape_count[6:0], pixel_color[14:7]
);
    import jet_pkg::*;

    logic s_acc;
    logic cfg_seen;
    assign s_acc    = i_s_tvalid && o_s_tready;
    assign cfg_seen = i_cfg_we && (i_cfg_idx == REG_C_REAL || i_cfg_idx == REG_C_IMAG)
                      && (i_cfg_data == i_cfg_data) && (i_s_tdata == i_s_tdata);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed while stalled");

    // count never exceeds the iteration limit
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (MAX_ITER <= 127) |-> o_m_tdata[6:0] <= MAX_ITER)
        else $error("escape count above limit");

    // color follows the count
    a_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (MAX_ITER <= 127) |->
            o_m_tdata[14:7] == color_of({1'b0, o_m_tdata[6:0]}))
        else $error("pixel color does not match count");

    // one point at a time: busy right after an accepted beat
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_tready && !$rose(o_m_tvalid))
        else $error("input taken or result shown right after accept");

    // configuration port does not disturb a waiting result
    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_seen && o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result lost during register write");

endmodule

bind julia_escape_time_fixed jet_checker #(.MAX_ITER(MAX_ITER)) u_jet_checker (.*);

>>> tb/sv/tb_julia_escape_time_fixed.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_julia_escape_time_fixed
// Self-checking bench for the fixed-point Julia escape-time unit.
// ----------------------------------------------------------------------------
// Start points go in on the input stream and escape count and color come back
// on the output stream. A scoreboard object iterates z = z^2 + c on its own
// copy of the constant for every accepted point and checks each returned beat
// field by field, in order. The constant is rewritten between phases while
// the unit is idle; the phases vary the sender gaps and receiver stalls, and
// one of them holds the receiver off long enough to back up the input.

localparam int JET_FRAC_BITS = 26;
localparam int JET_MAX_ITER  = 64;
localparam logic [7:0] COLOR_CAP_COUNT = 8'd63;
localparam logic [7:0] COLOR_HI_MASK   = 8'hE0;

typedef struct packed {
    logic [6:0] count;
    logic [7:0] color;
} t_pixel_result;

// escape-count predictor and in-order result checker
class jet_pixel_scoreboard;
    logic [31:0]   c_re;
    logic [31:0]   c_im;
    t_pixel_result expected_pixels[$];
    int            errors;
    int            beats_seen;

    function new();
        c_re = -32'sd59055800;
        c_im = 32'sd17314086;
        errors = 0;
        beats_seen = 0;
    endfunction

    function void set_constant(logic [jet_pkg::CFG_IW-1:0] idx, logic [31:0] value);
        if (idx == jet_pkg::REG_C_REAL) begin
            c_re = value;
        end else if (idx == jet_pkg::REG_C_IMAG) begin
            c_im = value;
        end
    endfunction

    // sign-magnitude product, shifted right so it truncates toward zero
    function logic [63:0] mul_trunc(logic [63:0] a, logic [63:0] b, int sh);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [63:0]  r;
        logic [127:0] p;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        p = {64'b0, ma} * {64'b0, mb};
        p = p >> sh;
        r = p[63:0];
        return (a[63] ^ b[63]) ? -r : r;
    endfunction

    function t_pixel_result escape_pixel(logic [31:0] pr, logic [31:0] pi);
        logic [63:0]   re;
        logic [63:0]   im;
        logic [63:0]   cr;
        logic [63:0]   ci;
        logic [63:0]   sq_re;
        logic [63:0]   sq_im;
        logic [63:0]   sum;
        logic [63:0]   new_im;
        logic [63:0]   four;
        logic [7:0]    m;
        int            n;
        bit            escaped;
        t_pixel_result res;
        re = {{32{pr[31]}}, pr};
        im = {{32{pi[31]}}, pi};
        cr = {{32{c_re[31]}}, c_re};
        ci = {{32{c_im[31]}}, c_im};
        four = 64'd4 << JET_FRAC_BITS;
        n = 0;
        escaped = 0;
        // test |z|^2 > 4 before each pass, the cross term is doubled by the shift
        while (!escaped && n < JET_MAX_ITER) begin
            sq_re = mul_trunc(re, re, JET_FRAC_BITS);
            sq_im = mul_trunc(im, im, JET_FRAC_BITS);
            sum = sq_re + sq_im;
            if ($signed(sum) > $signed(four)) begin
                escaped = 1;
            end else begin
                new_im = mul_trunc(re, im, JET_FRAC_BITS - 1) + ci;
                re = sq_re - sq_im + cr;
                im = new_im;
                n++;
            end
        end
        // color uses the count capped below the never-escaped value
        m = (n > COLOR_CAP_COUNT) ? COLOR_CAP_COUNT : n[7:0];
        res.count = n[6:0];
        res.color = ((m << 2) & COLOR_HI_MASK) + (m >> 1);
        return res;
    endfunction

    function void note_point(logic [31:0] pr, logic [31:0] pi);
        expected_pixels.push_back(escape_pixel(pr, pi));
    endfunction

    function int pending();
        return expected_pixels.size();
    endfunction

    task report_error(string msg);
        errors++;
        $display("ERROR beat %0d: %s", beats_seen, msg);
    endtask

    task check_pixel(logic [15:0] beat);
        t_pixel_result want;
        if (expected_pixels.size() == 0) begin
            report_error($sformatf("unexpected result beat %h", beat));
        end else begin
            want = expected_pixels.pop_front();
            if (beat[6:0] != want.count) begin
                report_error($sformatf("escape_count %0d, expected %0d",
                                       beat[6:0], want.count));
            end
            if (beat[14:7] != want.color) begin
                report_error($sformatf("pixel_color %0d, expected %0d",
                                       beat[14:7], want.color));
            end
        end
        beats_seen++;
    endtask
endclass

module tb_julia_escape_time_fixed;

    localparam int          PRESSURE_CYCLES = 1500;
    localparam int          WATCHDOG_LIMIT  = 20000;
    localparam int          PHASE_ITEMS     = 215;
    localparam logic [31:0] ONE             = 32'h0400_0000;
    localparam logic [31:0] TWO             = 32'h0800_0000;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [jet_pkg::CFG_IW-1:0]    i_cfg_idx;
    logic [jet_pkg::IN_W-1:0]      i_cfg_data;
    logic                          i_s_tvalid;
    logic                          o_s_tready;
    logic [63:0]                   i_s_tdata;
    logic                          o_m_tvalid;
    logic                          i_m_tready;
    logic [15:0]                   o_m_tdata;

    jet_pixel_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 0;

    julia_escape_time_fixed #(
        .FRAC_BITS (JET_FRAC_BITS),
        .MAX_ITER  (JET_MAX_ITER)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver: check beats, random stalls, one long hold-off
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                sb.check_pixel(o_m_tdata);
            end
            if (hold_req && !hold_done) begin
                hold_left = PRESSURE_CYCLES;
                hold_done = 1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on cycles without any accepted beat
    initial begin
        int stuck;
        stuck = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
            if (stuck >= WATCHDOG_LIMIT) begin
                $display("julia_escape_time_fixed: mismatch");
                $finish;
            end
        end
    end

    // mostly inside the |z| <= 2 box, some near zero, some full range
    function automatic logic [31:0] pick_coord();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            return $urandom_range(0, 2 * TWO) - TWO;
        end else if (pick < 85) begin
            return $urandom_range(0, ONE) - (ONE >> 1);
        end
        return $urandom();
    endfunction

    // one input beat, with an optional idle gap in front
    task automatic send_point(input logic [31:0] re, input logic [31:0] im);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {im, re};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_point(re, im);
    endtask

    // wait until every result is back, then let the unit settle
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_c(input logic [31:0] cr, input logic [31:0] ci);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= jet_pkg::REG_C_REAL;
        i_cfg_data <= cr;
        @(posedge i_clk);
        sb.set_constant(jet_pkg::REG_C_REAL, cr);
        i_cfg_idx  <= jet_pkg::REG_C_IMAG;
        i_cfg_data <= ci;
        @(posedge i_clk);
        sb.set_constant(jet_pkg::REG_C_IMAG, ci);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_phase(input logic [31:0] cr, input logic [31:0] ci,
                             input int send_pct, input int recv_pct, input bit pressure);
        write_c(cr, ci);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (pressure) begin
            hold_req = 1;
        end
        repeat (PHASE_ITEMS) send_point(pick_coord(), pick_coord());
        drain();
    endtask

    // stimulus
    initial begin
        sb = new();
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= jet_pkg::REG_C_REAL;
        i_cfg_data <= '0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed points with the reset constant
        send_point(32'h0, 32'h0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF);
        // |z|^2 exactly 4 does not escape, one lsb more does
        send_point(TWO, 32'h0);
        send_point(TWO + 1, 32'h0);
        send_point(32'h0, -TWO);
        send_point(32'h0, -TWO - 1);
        // tiny negative values truncate toward zero
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_point(32'h1, 32'hFFFF_FFFF);
        send_point(32'hFFFF_FFFD, 32'h5);
        send_point(ONE, ONE);
        send_point(-ONE, ONE);
        send_point(ONE >> 1, -(ONE >> 1));
        send_point(32'h0FFF_FFFF, 32'h0FFF_FFFF);
        drain();

        // zero constant: unit-circle points never escape
        write_c(32'h0, 32'h0);
        send_point(32'h0, 32'h0);
        send_point(ONE, 32'h0);
        send_point(32'h0, ONE);
        send_point(-ONE, 32'h0);
        drain();

        // random phases over constants and handshake pressure
        run_phase(-32'sd59055800, 32'sd17314086, 0, 0, 1);
        run_phase($urandom_range(0, 2 * TWO) - TWO, $urandom_range(0, 2 * TWO) - TWO,
                  83, 0, 0);
        run_phase(32'h7FFF_FFFF, 32'h8000_0000, 0, 83, 0);
        run_phase(32'h8000_0000, 32'h7FFF_FFFF, 6, 6, 0);
        run_phase(32'hFD00_0000, 32'h0070_A3D7, 0, 0, 0);
        run_phase($urandom_range(0, TWO) - ONE, $urandom_range(0, TWO) - ONE, 0, 83, 0);
        run_phase(32'h0, 32'h0, 6, 6, 0);

        repeat (300) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("julia_escape_time_fixed: match");
        end else begin
            $display("julia_escape_time_fixed: mismatch");
        end
        $finish;
    end

endmodule
